[sv/rthp_pkg.sv]
// ----------------------------------------------------------------------------
// rthp_pkg: shared types and constants of the RGB to HSV pixel unit
// Holds the channel and hue widths, the hue sector codes, and the job record
// that the classifier passes through the queue to the divider pipeline.
// ----------------------------------------------------------------------------
package rthp_pkg;

	localparam int CHAN_W            = 8;
	localparam int HUE_W             = 13;
	localparam int HUE_FRAC_BITS_DEF = 4;

	// Hue sector bases in whole degrees.
	localparam int HUE_BASE_BLUE_MIN  = 60;
	localparam int HUE_BASE_RED_MIN   = 180;
	localparam int HUE_BASE_GREEN_MIN = 300;

	// Depth of the queue between the classifier and the divider.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		SECT_GRAY,
		SECT_BLUE_MIN,
		SECT_RED_MIN,
		SECT_GREEN_MIN
	} sector_t;

	// One classified pixel: sector, sign and magnitude of the channel
	// difference, chroma and brightness.
	typedef struct packed {
		sector_t           sector;
		logic              neg;
		logic [CHAN_W-1:0] mag;
		logic [CHAN_W-1:0] chroma;
		logic [CHAN_W-1:0] brightness;
	} hsv_job_t;

endpackage

[sv/rthp_classify.sv]
// ----------------------------------------------------------------------------
// rthp_classify: pixel classifier
// Finds the largest and smallest channel, the chroma, the hue sector and the
// signed channel difference that the divider needs.
// ----------------------------------------------------------------------------
module rthp_classify (
	input  logic [rthp_pkg::CHAN_W-1:0] red,
	input  logic [rthp_pkg::CHAN_W-1:0] green,
	input  logic [rthp_pkg::CHAN_W-1:0] blue,
	output rthp_pkg::hsv_job_t          job
);

	logic [rthp_pkg::CHAN_W-1:0] hi;
	logic [rthp_pkg::CHAN_W-1:0] lo;

	always_comb begin
		hi = red;
		if (green > hi) hi = green;
		if (blue > hi) hi = blue;
		lo = red;
		if (green < lo) lo = green;
		if (blue < lo) lo = blue;
	end

	// Ties for the minimum resolve in the order blue, red, green.
	always_comb begin
		job.chroma     = hi - lo;
		job.brightness = hi;
		job.sector     = rthp_pkg::SECT_GRAY;
		job.neg        = 1'b0;
		job.mag        = '0;
		if (hi != lo) begin
			if (lo == blue) begin
				job.sector = rthp_pkg::SECT_BLUE_MIN;
				job.neg    = green < red;
				job.mag    = job.neg ? red - green : green - red;
			end else if (lo == red) begin
				job.sector = rthp_pkg::SECT_RED_MIN;
				job.neg    = blue < green;
				job.mag    = job.neg ? green - blue : blue - green;
			end else begin
				job.sector = rthp_pkg::SECT_GREEN_MIN;
				job.neg    = red < blue;
				job.mag    = job.neg ? blue - red : red - blue;
			end
		end
	end

endmodule

[sv/rthp_queue.sv]
// ----------------------------------------------------------------------------
// rthp_queue: job queue
// A short register queue that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
module rthp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  rthp_pkg::hsv_job_t wr_job,
	output logic               full,
	input  logic               rd_en,
	output logic               rd_valid,
	output rthp_pkg::hsv_job_t rd_job
);

	rthp_pkg::hsv_job_t                   entry_q [rthp_pkg::QUEUE_DEPTH];
	logic [rthp_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [rthp_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [rthp_pkg::QUEUE_CNT_W-1:0]     count_q;
	logic                                 do_wr;
	logic                                 do_rd;

	assign full     = count_q == rthp_pkg::QUEUE_CNT_W'(rthp_pkg::QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_job   = entry_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_job;
	end

endmodule

[sv/rthp_divide.sv]
// ----------------------------------------------------------------------------
// rthp_divide: hue divider pipeline
// Scales the channel difference, divides it by the chroma one quotient bit
// per stage, and adds the sector base into the registered result.
// ----------------------------------------------------------------------------
module rthp_divide #(
	parameter int HUE_FRAC_BITS = rthp_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  rthp_pkg::hsv_job_t          job,
	output logic                        job_take,
	input  logic                        pop,
	output logic                        empty,
	output logic [rthp_pkg::HUE_W-1:0]  hue,
	output logic [rthp_pkg::CHAN_W-1:0] chroma,
	output logic [rthp_pkg::CHAN_W-1:0] brightness
);

	localparam int CW    = rthp_pkg::CHAN_W;
	// 60 * 2^F * |diff| / chroma stays below 64 * 2^F.
	localparam int QUO_W = HUE_FRAC_BITS + 6;
	localparam int SUM_W = (HUE_FRAC_BITS + 9 > rthp_pkg::HUE_W) ?
		HUE_FRAC_BITS + 9 : rthp_pkg::HUE_W;
	localparam logic [SUM_W-1:0] BASE_BLUE_MIN  =
		SUM_W'(rthp_pkg::HUE_BASE_BLUE_MIN << HUE_FRAC_BITS);
	localparam logic [SUM_W-1:0] BASE_RED_MIN   =
		SUM_W'(rthp_pkg::HUE_BASE_RED_MIN << HUE_FRAC_BITS);
	localparam logic [SUM_W-1:0] BASE_GREEN_MIN =
		SUM_W'(rthp_pkg::HUE_BASE_GREEN_MIN << HUE_FRAC_BITS);

	logic                  valid_s  [QUO_W+1];
	logic [CW-1:0]         rem_s    [QUO_W+1];
	logic [QUO_W-1:0]      num_s    [QUO_W+1];
	logic [QUO_W-1:0]      quo_s    [QUO_W+1];
	rthp_pkg::sector_t     sector_s [QUO_W+1];
	logic                  neg_s    [QUO_W+1];
	logic [CW-1:0]         chroma_s [QUO_W+1];
	logic [CW-1:0]         bright_s [QUO_W+1];

	logic                  out_valid_q;
	logic [rthp_pkg::HUE_W-1:0] hue_q;
	logic [CW-1:0]         chroma_q;
	logic [CW-1:0]         bright_q;

	logic                  advance;
	logic [13:0]           prod;
	logic [SUM_W-1:0]      base;
	logic [SUM_W-1:0]      quo_ext;
	logic [SUM_W-1:0]      sum;

	// The whole pipeline moves together whenever the output register is free or popped.
	assign advance  = !out_valid_q || pop;
	assign job_take = advance && job_valid;

	// |diff| * 60 as two shifts and a subtract.
	assign prod = ({6'b0, job.mag} << 6) - ({6'b0, job.mag} << 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (advance) begin
			valid_s[0] <= job_valid;
		end
	end

	// The upper byte of the scaled numerator is already below the chroma.
	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0]    <= prod[13:6];
			num_s[0]    <= QUO_W'(prod[5:0]) << HUE_FRAC_BITS;
			quo_s[0]    <= '0;
			sector_s[0] <= job.sector;
			neg_s[0]    <= job.neg;
			chroma_s[0] <= job.chroma;
			bright_s[0] <= job.brightness;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [CW:0] trial;
		logic [CW:0] diff;
		logic        ge;

		assign trial = {rem_s[k-1], num_s[k-1][QUO_W-1]};
		assign diff  = trial - {1'b0, chroma_s[k-1]};
		assign ge    = trial >= {1'b0, chroma_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (advance) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k]    <= ge ? diff[CW-1:0] : trial[CW-1:0];
				num_s[k]    <= num_s[k-1] << 1;
				quo_s[k]    <= {quo_s[k-1][QUO_W-2:0], ge};
				sector_s[k] <= sector_s[k-1];
				neg_s[k]    <= neg_s[k-1];
				chroma_s[k] <= chroma_s[k-1];
				bright_s[k] <= bright_s[k-1];
			end
		end
	end

	always_comb begin
		case (sector_s[QUO_W])
			rthp_pkg::SECT_BLUE_MIN:  base = BASE_BLUE_MIN;
			rthp_pkg::SECT_RED_MIN:   base = BASE_RED_MIN;
			rthp_pkg::SECT_GREEN_MIN: base = BASE_GREEN_MIN;
			default:                  base = '0;
		endcase
	end

	// The truncated quotient never exceeds the base, so the difference never goes negative.
	assign quo_ext = SUM_W'(quo_s[QUO_W]);
	assign sum = (sector_s[QUO_W] == rthp_pkg::SECT_GRAY) ? '0 :
		(neg_s[QUO_W] ? base - quo_ext : base + quo_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hue_q    <= sum[rthp_pkg::HUE_W-1:0];
			chroma_q <= chroma_s[QUO_W];
			bright_q <= bright_s[QUO_W];
		end
	end

	assign empty      = !out_valid_q;
	assign hue        = hue_q;
	assign chroma     = chroma_q;
	assign brightness = bright_q;

endmodule

[sv/rgb_to_hsv_pixel_unit.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_unit: RGB to hue, chroma and value converter
// Throughput: one pixel per cycle, set by the divider, while results are popped.
// Reset: arst_n clears the queue and all valid flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_unit #(
	parameter int HUE_FRAC_BITS = rthp_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [rthp_pkg::CHAN_W-1:0] red,
	input  logic [rthp_pkg::CHAN_W-1:0] green,
	input  logic [rthp_pkg::CHAN_W-1:0] blue,
	output logic                        empty,
	input  logic                        pop,
	output logic [rthp_pkg::HUE_W-1:0]  hue,
	output logic [rthp_pkg::CHAN_W-1:0] chroma,
	output logic [rthp_pkg::CHAN_W-1:0] brightness
);

	// The front end classifies each pixel in the cycle it arrives: it finds
	// the largest and smallest channel, the chroma, and which channel is the
	// minimum. That choice picks the hue sector and the signed channel
	// difference that must be divided by the chroma.
	rthp_pkg::hsv_job_t new_job;
	rthp_pkg::hsv_job_t queued_job;
	logic               queued_valid;
	logic               queued_take;

	rthp_classify u_classify (
		.red   (red),
		.green (green),
		.blue  (blue),
		.job   (new_job)
	);

	// A push transaction lands in a short queue. The queue lets the input
	// side keep taking pixels until it is full while the result side is
	// stalled, and it isolates the input handshake from the pipeline enable.
	rthp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_job   (new_job),
		.full     (full),
		.rd_en    (queued_take),
		.rd_valid (queued_valid),
		.rd_job   (queued_job)
	);

	// The back end scales the difference by 60 degrees in fixed point and
	// runs a restoring division, one quotient bit per stage, so a new pixel
	// can enter every cycle. The quotient is truncated toward zero and the
	// sector base is added afterward. The last stage is the output register;
	// the pipeline holds still only while that register waits for a pop
	// transaction.
	rthp_divide #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS)
	) u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (queued_valid),
		.job        (queued_job),
		.job_take   (queued_take),
		.pop        (pop),
		.empty      (empty),
		.hue        (hue),
		.chroma     (chroma),
		.brightness (brightness)
	);

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB to HSV pixel unit
// Pixels go in through the push/full side and results come out through the
// empty/pop side. Each accepted pixel is converted to hue, chroma and
// brightness by a local predictor, and every popped result is compared with
// the oldest prediction. Both sides idle at random in several phases. The
// receiver also holds off once so that the unit fills up, and the sender
// pauses once until the unit has drained.
// ----------------------------------------------------------------------------
module tb_top;

	// The unit runs at its default hue precision.
	localparam int HUE_FRAC       = rthp_pkg::HUE_FRAC_BITS_DEF;
	localparam int LATENCY        = HUE_FRAC + 8;
	localparam int DEG_PER_SECTOR = 60;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int CYCLE_LIMIT    = 200000;
	// The receiver stops popping for a long stretch once this many pixels
	// have been accepted, and the sender later pauses until the unit has drained.
	localparam int HOLD_AT        = 250;
	localparam int HOLD_CYCLES    = 100;
	localparam int PAUSE_AT       = 700;

	typedef struct {
		logic [rthp_pkg::CHAN_W-1:0] r;
		logic [rthp_pkg::CHAN_W-1:0] g;
		logic [rthp_pkg::CHAN_W-1:0] b;
	} rgb_pixel_t;

	typedef struct {
		logic [rthp_pkg::HUE_W-1:0]  hue;
		logic [rthp_pkg::CHAN_W-1:0] chroma;
		logic [rthp_pkg::CHAN_W-1:0] brightness;
	} pixel_hsv_t;

	logic                        clk    = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        push   = 1'b0;
	logic                        pop    = 1'b0;
	logic [rthp_pkg::CHAN_W-1:0] red    = '0;
	logic [rthp_pkg::CHAN_W-1:0] green  = '0;
	logic [rthp_pkg::CHAN_W-1:0] blue   = '0;
	logic                        full;
	logic                        empty;
	logic [rthp_pkg::HUE_W-1:0]  hue;
	logic [rthp_pkg::CHAN_W-1:0] chroma;
	logic [rthp_pkg::CHAN_W-1:0] brightness;

	// Pixels waiting to be offered, and conversions waiting to be popped.
	rgb_pixel_t pixel_backlog[$];
	pixel_hsv_t hsv_pending[$];

	int  total_items    = 0;
	int  items_accepted = 0;
	int  mismatch_cnt   = 0;
	int  cycle_cnt      = 0;
	int  hold_left      = 0;
	int  sender_idle_pct;
	int  receiver_idle_pct;
	bit  offer_taken    = 1'b0;
	bit  hold_done      = 1'b0;
	bit  pause_done     = 1'b0;

	rgb_to_hsv_pixel_unit #(
		.HUE_FRAC_BITS(HUE_FRAC)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.empty      (empty),
		.pop        (pop),
		.hue        (hue),
		.chroma     (chroma),
		.brightness (brightness)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Converts one pixel. The hue sector is picked by the minimum channel,
	// checked blue first, then red, then green, so ties go to the first of
	// those. The scaled difference term is divided as signed integers, which
	// truncates toward zero, and the sector base is added afterward.
	function automatic pixel_hsv_t predict_hsv(
			logic [rthp_pkg::CHAN_W-1:0] r,
			logic [rthp_pkg::CHAN_W-1:0] g,
			logic [rthp_pkg::CHAN_W-1:0] b);
		pixel_hsv_t                  res;
		logic [rthp_pkg::CHAN_W-1:0] hi;
		logic [rthp_pkg::CHAN_W-1:0] lo;
		int                          scale;
		int                          base;
		int                          diff;
		int                          h;
		hi = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		scale = 1 << HUE_FRAC;
		h     = 0;
		if (hi != lo) begin
			if (lo == b) begin
				base = rthp_pkg::HUE_BASE_BLUE_MIN;
				diff = int'(g) - int'(r);
			end else if (lo == r) begin
				base = rthp_pkg::HUE_BASE_RED_MIN;
				diff = int'(b) - int'(g);
			end else begin
				base = rthp_pkg::HUE_BASE_GREEN_MIN;
				diff = int'(r) - int'(b);
			end
			h = base * scale + (DEG_PER_SECTOR * scale * diff) / int'(hi - lo);
		end
		res.hue        = h[rthp_pkg::HUE_W-1:0];
		res.chroma     = hi - lo;
		res.brightness = hi;
		return res;
	endfunction

	task automatic add_pixel(
			logic [rthp_pkg::CHAN_W-1:0] r,
			logic [rthp_pkg::CHAN_W-1:0] g,
			logic [rthp_pkg::CHAN_W-1:0] b);
		rgb_pixel_t px;
		px.r = r;
		px.g = g;
		px.b = b;
		pixel_backlog.push_back(px);
	endtask

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			mismatch_cnt++;
		end
	endtask

	// Picks one channel value that is often an extreme of the range.
	function automatic logic [rthp_pkg::CHAN_W-1:0] edge_channel();
		case ($urandom_range(2))
			0: return '0;
			1: return '1;
			default: return rthp_pkg::CHAN_W'($urandom);
		endcase
	endfunction

	// The idle rates depend on how far the run has come: first the sender
	// idles rarely and the receiver often, then the other way round, and
	// in the last third neither side idles.
	always_comb begin
		if (items_accepted < total_items / 3) begin
			sender_idle_pct   = 11;
			receiver_idle_pct = 66;
		end else if (items_accepted < 2 * total_items / 3) begin
			sender_idle_pct   = 66;
			receiver_idle_pct = 11;
		end else begin
			sender_idle_pct   = 0;
			receiver_idle_pct = 0;
		end
	end

	// Monitor. Everything is sampled at the rising edge, where the inputs set
	// at the falling edge are stable and the outputs still hold the values of
	// the cycle that ends. An input transaction records its prediction; an
	// output transaction is checked against the oldest one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				hsv_pending.push_back(predict_hsv(red, green, blue));
				items_accepted++;
				offer_taken = 1'b1;
			end
			if (pop && !empty) begin
				if (hsv_pending.size() == 0) begin
					$display("%0t: result with no pixel waiting, hue %0d chroma %0d brightness %0d",
						$time, hue, chroma, brightness);
					mismatch_cnt++;
				end else begin
					check_field("hue", hsv_pending[0].hue, hue);
					check_field("chroma", hsv_pending[0].chroma, chroma);
					check_field("brightness", hsv_pending[0].brightness, brightness);
					void'(hsv_pending.pop_front());
				end
			end
		end
	end

	// Driver. A pixel that is on offer stays on the ports until a transaction
	// takes it. Only then, or while nothing is on offer, does the driver pick
	// the next pixel or an idle cycle. Once, the sender holds back until every
	// prediction has been popped, so the unit runs fully empty mid-stream.
	always @(negedge clk) begin
		if (arst_n && (!push || offer_taken)) begin
			offer_taken = 1'b0;
			if (items_accepted == PAUSE_AT && !pause_done) begin
				push <= 1'b0;
				if (hsv_pending.size() == 0)
					pause_done = 1'b1;
			end else if (pixel_backlog.size() != 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				red   <= pixel_backlog[0].r;
				green <= pixel_backlog[0].g;
				blue  <= pixel_backlog[0].b;
				push  <= 1'b1;
				void'(pixel_backlog.pop_front());
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver. Besides the random idling, it stops popping once for a long
	// stretch while the sender keeps offering, which fills the unit and makes
	// it raise full.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (items_accepted >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Guard against a hung unit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		rgb_pixel_t px;
		int         sel;

		// Directed pixels: black, white and mid gray, the primaries and
		// secondaries, the smallest nonzero chroma, full chroma, ties for the
		// minimum in each order, and negative differences in every sector.
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_pixel(8'd128, 8'd128, 8'd128);
		add_pixel(8'd255, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd255);
		add_pixel(8'd255, 8'd255, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd255);
		add_pixel(8'd255, 8'd0, 8'd255);
		add_pixel(8'd1, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd1, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd1);
		add_pixel(8'd5, 8'd200, 8'd5);
		add_pixel(8'd5, 8'd5, 8'd200);
		add_pixel(8'd200, 8'd5, 8'd5);
		add_pixel(8'd200, 8'd100, 8'd0);
		add_pixel(8'd0, 8'd200, 8'd100);
		add_pixel(8'd100, 8'd0, 8'd200);
		add_pixel(8'd1, 8'd255, 8'd0);
		add_pixel(8'd254, 8'd255, 8'd253);
		add_pixel(8'd255, 8'd254, 8'd0);
		add_pixel(8'd0, 8'd254, 8'd255);

		// Random pixels: mostly uniform, with gray pixels, two-channel ties
		// and extreme channel values mixed in.
		repeat (RANDOM_ITEMS) begin
			px.r = rthp_pkg::CHAN_W'($urandom);
			px.g = rthp_pkg::CHAN_W'($urandom);
			px.b = rthp_pkg::CHAN_W'($urandom);
			sel  = $urandom_range(9);
			case (sel)
				0: begin
					px.g = px.r;
					px.b = px.r;
				end
				1: begin
					case ($urandom_range(2))
						0: px.g = px.r;
						1: px.b = px.r;
						default: px.b = px.g;
					endcase
				end
				2: begin
					px.r = edge_channel();
					px.g = edge_channel();
					px.b = edge_channel();
				end
				default: ;
			endcase
			pixel_backlog.push_back(px);
		end
		total_items = pixel_backlog.size();

		// Reset is held from the start and released at a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every pixel has been taken, then until every result has
		// been popped, then a little longer to catch stray results.
		while (pixel_backlog.size() != 0 || push)
			@(posedge clk);
		while (hsv_pending.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (hsv_pending.size() != 0) begin
			$display("%0t: %0d predictions left over", $time, hsv_pending.size());
			mismatch_cnt++;
		end
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
